// ===== hw/rtl/timed_pulse_slot_table_assert.svh =====
// assertion helpers for the pulse slot table, clocked on clock, disabled in reset
`ifndef TIMED_PULSE_SLOT_TABLE_ASSERT_SVH
`define TIMED_PULSE_SLOT_TABLE_ASSERT_SVH

// same-cycle implication
`define TPST_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TPST_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/tpst_pkg.sv =====
`default_nettype none

package tpst_pkg;

   localparam int CSR_IDX_W = 3;
   localparam int PROD_W    = 61;
   localparam int MS_SHIFT  = 38;

   localparam logic [28:0] MS_RECIP         = 29'd274877907;
   localparam logic [31:0] DEFAULT_PULSE_MS = 32'd1000;

   localparam logic CMD_ARM  = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_BOUNDS = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;
   localparam logic [1:0] ST_JITTER = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_CHECK_FIXED_RATE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SCAN_PERIOD      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED_ADDRESS   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_REGION_MASK      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CONSTANT_REGION  = 3'd4;

   localparam logic [15:0] RST_UNUSED_ADDRESS  = 16'hFFFF;
   localparam logic [15:0] RST_REGION_MASK     = 16'hF000;
   localparam logic [15:0] RST_CONSTANT_REGION = 16'hF000;

   typedef struct packed {
      logic        check_fixed_rate;
      logic [31:0] scan_period;
      logic [15:0] unused_address;
      logic [15:0] region_mask;
      logic [15:0] constant_region;
      logic [31:0] previous_tick_us;
   } cfg_type;

   typedef struct packed {
      logic [15:0] address;
      logic [31:0] length;
      logic [31:0] deadline;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);

endpackage

`default_nettype wire

// ===== hw/rtl/tpst_ram.sv =====
`default_nettype none

module tpst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic                                     rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/tpst_csr.sv =====
`default_nettype none

module tpst_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [tpst_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]                    csr_wdata,
   input  wire logic                           tick_wr,
   input  wire logic [31:0]                    tick_value,
   output tpst_pkg::cfg_type                   cfg
);

   tpst_pkg::cfg_type cfg_ff;
   tpst_pkg::cfg_type cfg_in;
   logic              wr;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid && csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (tick_wr) begin
         cfg_in.previous_tick_us = tick_value;
      end
      if (wr) begin
         case (csr_index)
            tpst_pkg::REG_CHECK_FIXED_RATE: begin
               cfg_in.check_fixed_rate = csr_wdata[0];
               cfg_in.previous_tick_us = '0;
            end
            tpst_pkg::REG_SCAN_PERIOD: begin
               cfg_in.scan_period      = csr_wdata;
               cfg_in.previous_tick_us = '0;
            end
            tpst_pkg::REG_UNUSED_ADDRESS:  cfg_in.unused_address  = csr_wdata[15:0];
            tpst_pkg::REG_REGION_MASK:     cfg_in.region_mask     = csr_wdata[15:0];
            tpst_pkg::REG_CONSTANT_REGION: cfg_in.constant_region = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.check_fixed_rate <= 1'b0;
         cfg_ff.scan_period      <= '0;
         cfg_ff.unused_address   <= tpst_pkg::RST_UNUSED_ADDRESS;
         cfg_ff.region_mask      <= tpst_pkg::RST_REGION_MASK;
         cfg_ff.constant_region  <= tpst_pkg::RST_CONSTANT_REGION;
         cfg_ff.previous_tick_us <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/timed_pulse_slot_table.sv =====
`default_nettype none
// channel   | handshake               | ports
// ----------+-------------------------+---------------------------------------------
// request   | start, busy             | req_cmd, req_target_address,
//           |                         | req_pulse_length_ms, req_tick_time_us
// response  | rsp_strobe (no stall)   | rsp_drive_valid, rsp_drive_address,
//           |                         | rsp_drive_level, rsp_status, rsp_last
// csr       | csr_valid, csr_ready    | csr_index, csr_wdata
//
// arm and tick walk the slot ram one entry a cycle: busy stays high through S_PREP and
// the walk, and a new word is taken only once busy has fallen
// rejected arm or jittered tick: busy for 1 cycle (S_PREP), then the next word is taken
// slot busy bits are flops cleared by reset; the slot ram needs no clearing pass
// responses leave in the cycle after they are decided, one per cycle, never held off

module timed_pulse_slot_table #(
   parameter int SLOT_COUNT = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_cmd,
   input  wire logic [15:0] req_target_address,
   input  wire logic [31:0] req_pulse_length_ms,
   input  wire logic [31:0] req_tick_time_us,
   output logic             rsp_strobe,
   output logic             rsp_drive_valid,
   output logic [15:0]      rsp_drive_address,
   output logic             rsp_drive_level,
   output logic [1:0]       rsp_status,
   output logic             rsp_last,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [tpst_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0] csr_wdata
);

`include "timed_pulse_slot_table_assert.svh"

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W = $clog2(SLOT_COUNT + 1);
   localparam logic [CNT_W-1:0] CNT_END = CNT_W'(SLOT_COUNT);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_PREP = 2'd1;
   localparam logic [1:0] S_WALK = 2'd2;

   logic [1:0]                  state_ff, state_in;
   logic                        cmd_ff;
   logic [15:0]                 addr_ff;
   logic [31:0]                 len_ff;
   logic [31:0]                 tick_ff;
   logic [tpst_pkg::PROD_W-1:0] prod_ff;
   logic [CNT_W-1:0]            rd_cnt_ff, rd_cnt_in;
   logic                        pv_ff, pv_in;
   logic [IDX_W-1:0]            pidx_ff, pidx_in;
   logic                        match_ff, match_in;
   logic [IDX_W-1:0]            match_idx_ff, match_idx_in;
   logic [SLOT_COUNT-1:0]       busy_ff, busy_in;

   logic                        rsp_strobe_ff, rsp_strobe_in;
   logic                        rsp_drive_valid_ff, rsp_drive_valid_in;
   logic [15:0]                 rsp_drive_address_ff, rsp_drive_address_in;
   logic                        rsp_drive_level_ff, rsp_drive_level_in;
   logic [1:0]                  rsp_status_ff, rsp_status_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic                        ram_wr_en;
   logic [IDX_W-1:0]            ram_wr_addr;
   tpst_pkg::slot_type          ram_wr_data;
   logic                        ram_rd_en;
   logic [IDX_W-1:0]            ram_rd_addr;
   tpst_pkg::slot_type          ram_rd_data;

   tpst_pkg::cfg_type           cfg;
   logic                        tick_wr;
   logic                        accept;
   logic                        rate_on;
   logic [31:0]                 now_ms;
   logic                        free_any;
   logic [IDX_W-1:0]            free_idx;
   logic [IDX_W-1:0]            slot_sel;

   tpst_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .tick_wr    (tick_wr),
      .tick_value (tick_ff),
      .cfg        (cfg)
   );

   tpst_ram #(
      .WIDTH (tpst_pkg::SLOT_W),
      .DEPTH (SLOT_COUNT)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign busy    = (state_ff != S_IDLE);
   assign accept  = start && !busy;
   assign rate_on = cfg.check_fixed_rate && (cfg.scan_period != '0);
   assign now_ms  = 32'(prod_ff >> tpst_pkg::MS_SHIFT);

   // lowest free slot
   always_comb begin
      free_idx = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (!busy_ff[i]) begin
            free_idx = IDX_W'(i);
         end
      end
   end

   assign free_any = ~&busy_ff;
   assign slot_sel = match_ff ? match_idx_ff : free_idx;

   always_comb begin
      state_in             = state_ff;
      rd_cnt_in            = rd_cnt_ff;
      pv_in                = 1'b0;
      pidx_in              = pidx_ff;
      match_in             = match_ff;
      match_idx_in         = match_idx_ff;
      busy_in              = busy_ff;
      tick_wr              = 1'b0;
      ram_wr_en            = 1'b0;
      ram_wr_addr          = pidx_ff;
      ram_wr_data          = ram_rd_data;
      ram_rd_en            = 1'b0;
      ram_rd_addr          = rd_cnt_ff[IDX_W-1:0];
      rsp_strobe_in        = 1'b0;
      rsp_drive_valid_in   = 1'b0;
      rsp_drive_address_in = '0;
      rsp_drive_level_in   = 1'b0;
      rsp_status_in        = tpst_pkg::ST_OK;
      rsp_last_in          = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in  = S_PREP;
               rd_cnt_in = '0;
               match_in  = 1'b0;
            end
         end
         S_PREP: begin
            if (cmd_ff == tpst_pkg::CMD_ARM) begin
               if (addr_ff == cfg.unused_address ||
                   (addr_ff & cfg.region_mask) == cfg.constant_region) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = tpst_pkg::ST_BOUNDS;
                  rsp_last_in   = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  state_in = S_WALK;
               end
            end else begin
               if (rate_on && cfg.previous_tick_us != '0 &&
                   tick_ff != cfg.previous_tick_us + cfg.scan_period) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = tpst_pkg::ST_JITTER;
                  rsp_last_in   = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  tick_wr  = rate_on;
                  state_in = S_WALK;
               end
            end
         end
         S_WALK: begin
            if (rd_cnt_ff != CNT_END) begin
               ram_rd_en = 1'b1;
               rd_cnt_in = rd_cnt_ff + CNT_W'(1);
               pv_in     = 1'b1;
               pidx_in   = rd_cnt_ff[IDX_W-1:0];
            end
            if (pv_ff && busy_ff[pidx_ff]) begin
               if (cmd_ff == tpst_pkg::CMD_TICK) begin
                  if (ram_rd_data.deadline == '0) begin
                     ram_wr_en            = 1'b1;
                     ram_wr_data.deadline = now_ms + ram_rd_data.length;
                  end else if (now_ms >= ram_rd_data.deadline) begin
                     rsp_strobe_in        = 1'b1;
                     rsp_drive_valid_in   = 1'b1;
                     rsp_drive_address_in = ram_rd_data.address;
                     busy_in[pidx_ff]     = 1'b0;
                  end
               end else if (!match_ff && ram_rd_data.address == addr_ff) begin
                  match_in     = 1'b1;
                  match_idx_in = pidx_ff;
               end
            end
            if (rd_cnt_ff == CNT_END && !pv_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
               if (cmd_ff == tpst_pkg::CMD_ARM) begin
                  if (match_ff || free_any) begin
                     ram_wr_en            = 1'b1;
                     ram_wr_addr          = slot_sel;
                     ram_wr_data.address  = addr_ff;
                     ram_wr_data.length   = len_ff;
                     ram_wr_data.deadline = '0;
                     busy_in[slot_sel]    = 1'b1;
                     rsp_drive_valid_in   = 1'b1;
                     rsp_drive_address_in = addr_ff;
                     rsp_drive_level_in   = 1'b1;
                  end else begin
                     rsp_status_in = tpst_pkg::ST_FULL;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rd_cnt_ff     <= '0;
         pv_ff         <= 1'b0;
         pidx_ff       <= '0;
         match_ff      <= 1'b0;
         match_idx_ff  <= '0;
         busy_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_cnt_ff     <= rd_cnt_in;
         pv_ff         <= pv_in;
         pidx_ff       <= pidx_in;
         match_ff      <= match_in;
         match_idx_ff  <= match_idx_in;
         busy_ff       <= busy_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_cmd;
         addr_ff <= req_target_address;
         len_ff  <= (req_pulse_length_ms == '0) ? tpst_pkg::DEFAULT_PULSE_MS
                                                : req_pulse_length_ms;
         tick_ff <= req_tick_time_us;
         // divide by 1000 through the reciprocal
         prod_ff <= tpst_pkg::PROD_W'(req_tick_time_us) *
                    tpst_pkg::PROD_W'(tpst_pkg::MS_RECIP);
      end
      rsp_drive_valid_ff   <= rsp_drive_valid_in;
      rsp_drive_address_ff <= rsp_drive_address_in;
      rsp_drive_level_ff   <= rsp_drive_level_in;
      rsp_status_ff        <= rsp_status_in;
      rsp_last_ff          <= rsp_last_in;
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_drive_valid   = rsp_drive_valid_ff;
   assign rsp_drive_address = rsp_drive_address_ff;
   assign rsp_drive_level   = rsp_drive_level_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_last          = rsp_last_ff;

   `TPST_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted word did not raise busy")
   `TPST_ASSERT_NOW(a_mid_row_busy, rsp_strobe && !rsp_last, busy,
      "non-final response word while idle")
   `TPST_ASSERT_NOW(a_error_row, rsp_strobe && rsp_status != tpst_pkg::ST_OK,
      !rsp_drive_valid && rsp_last, "error response drives a level or is not final")

endmodule

`default_nettype wire

// ===== test/timed_pulse_slot_table_tb.sv =====
`timescale 1ns / 100ps

module timed_pulse_slot_table_tb;

   localparam int SLOTS = 8;
   localparam int POOL = 12;
   localparam int unsigned LIMIT = 300000;
   localparam logic [31:0] US_PER_MS = 32'd1000;

   typedef struct packed {
      logic        drive_valid;
      logic [15:0] drive_address;
      logic        drive_level;
      logic [1:0]  status;
      logic        last;
   } pulse_drive_type;

   class pulse_scoreboard;
      logic        check_fixed_rate;
      logic [31:0] scan_period;
      logic [15:0] unused_address;
      logic [15:0] region_mask;
      logic [15:0] constant_region;
      logic [31:0] previous_tick_us;
      logic        slot_busy [SLOTS];
      logic [15:0] slot_address [SLOTS];
      logic [31:0] slot_length [SLOTS];
      logic [31:0] slot_deadline [SLOTS];
      pulse_drive_type drive_queue [$];
      int errors;

      function new();
         check_fixed_rate = 1'b0;
         scan_period      = '0;
         unused_address   = tpst_pkg::RST_UNUSED_ADDRESS;
         region_mask      = tpst_pkg::RST_REGION_MASK;
         constant_region  = tpst_pkg::RST_CONSTANT_REGION;
         previous_tick_us = '0;
         for (int i = 0; i < SLOTS; i++) begin
            slot_busy[i]     = 1'b0;
            slot_address[i]  = '0;
            slot_length[i]   = '0;
            slot_deadline[i] = '0;
         end
         errors = 0;
      endfunction

      function int pending();
         return drive_queue.size();
      endfunction

      function void write_register(logic [tpst_pkg::CSR_IDX_W-1:0] idx, logic [31:0] data);
         case (idx)
            tpst_pkg::REG_CHECK_FIXED_RATE: begin
               check_fixed_rate = data[0];
               previous_tick_us = '0;
            end
            tpst_pkg::REG_SCAN_PERIOD: begin
               scan_period      = data;
               previous_tick_us = '0;
            end
            tpst_pkg::REG_UNUSED_ADDRESS:  unused_address  = data[15:0];
            tpst_pkg::REG_REGION_MASK:     region_mask     = data[15:0];
            tpst_pkg::REG_CONSTANT_REGION: constant_region = data[15:0];
            default: ;
         endcase
      endfunction

      function void queue_drive(logic v, logic [15:0] a, logic lvl, logic [1:0] st,
                                logic lst);
         pulse_drive_type w;
         w.drive_valid   = v;
         w.drive_address = a;
         w.drive_level   = lvl;
         w.status        = st;
         w.last          = lst;
         drive_queue.push_back(w);
      endfunction

      function void note_word(logic cmd, logic [15:0] addr, logic [31:0] len,
                              logic [31:0] now_us);
         logic [31:0] plen;
         logic [31:0] now_ms;
         int slot;
         slot = -1;
         if (cmd == tpst_pkg::CMD_ARM) begin
            if (addr == unused_address || (addr & region_mask) == constant_region) begin
               queue_drive(1'b0, '0, 1'b0, tpst_pkg::ST_BOUNDS, 1'b1);
               return;
            end
            plen = (len == '0) ? tpst_pkg::DEFAULT_PULSE_MS : len;
            for (int i = 0; i < SLOTS; i++)
               if (slot < 0 && slot_busy[i] && slot_address[i] == addr) slot = i;
            for (int i = 0; i < SLOTS; i++)
               if (slot < 0 && !slot_busy[i]) slot = i;
            if (slot < 0) begin
               queue_drive(1'b0, '0, 1'b0, tpst_pkg::ST_FULL, 1'b1);
               return;
            end
            slot_busy[slot]     = 1'b1;
            slot_address[slot]  = addr;
            slot_length[slot]   = plen;
            slot_deadline[slot] = '0;
            queue_drive(1'b1, addr, 1'b1, tpst_pkg::ST_OK, 1'b1);
         end else begin
            if (check_fixed_rate && scan_period != '0) begin
               if (previous_tick_us != '0 && now_us != previous_tick_us + scan_period) begin
                  queue_drive(1'b0, '0, 1'b0, tpst_pkg::ST_JITTER, 1'b1);
                  return;
               end
               previous_tick_us = now_us;
            end
            now_ms = now_us / US_PER_MS;
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_busy[i]) begin
                  if (slot_deadline[i] == '0) begin
                     slot_deadline[i] = now_ms + slot_length[i];
                  end else if (now_ms >= slot_deadline[i]) begin
                     queue_drive(1'b1, slot_address[i], 1'b0, tpst_pkg::ST_OK, 1'b0);
                     slot_busy[i]     = 1'b0;
                     slot_deadline[i] = '0;
                  end
               end
            end
            queue_drive(1'b0, '0, 1'b0, tpst_pkg::ST_OK, 1'b1);
         end
      endfunction

      function void check_word(pulse_drive_type got);
         pulse_drive_type exp_w;
         if (drive_queue.size() == 0) begin
            if (errors < 200)
               $display("%0t: unexpected word %h", $time, got);
            errors++;
            return;
         end
         exp_w = drive_queue.pop_front();
         if (got !== exp_w) begin
            if (errors < 200)
               $display("%0t: mismatch expected %h got %h", $time, exp_w, got);
            errors++;
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic                 req_cmd = tpst_pkg::CMD_ARM;
   logic [15:0]          req_target_address = '0;
   logic [31:0]          req_pulse_length_ms = '0;
   logic [31:0]          req_tick_time_us = '0;
   logic                 rsp_strobe;
   logic                 rsp_drive_valid;
   logic [15:0]          rsp_drive_address;
   logic                 rsp_drive_level;
   logic [1:0]           rsp_status;
   logic                 rsp_last;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [tpst_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]          csr_wdata = '0;

   pulse_scoreboard sb = new();
   int unsigned cycles = 0;
   bit steady = 1'b0;
   logic [31:0] wall_us;
   logic [15:0] addr_pool [POOL];

   timed_pulse_slot_table #(.SLOT_COUNT(SLOTS)) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_cmd(req_cmd),
      .req_target_address(req_target_address),
      .req_pulse_length_ms(req_pulse_length_ms),
      .req_tick_time_us(req_tick_time_us),
      .rsp_strobe(rsp_strobe),
      .rsp_drive_valid(rsp_drive_valid),
      .rsp_drive_address(rsp_drive_address),
      .rsp_drive_level(rsp_drive_level),
      .rsp_status(rsp_status),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("** timed_pulse_slot_table: FAILED **");
         $finish;
      end else if (!reset && rsp_strobe) begin
         sb.check_word({rsp_drive_valid, rsp_drive_address, rsp_drive_level, rsp_status,
                        rsp_last});
      end
   end

   task send_word(logic cmd, logic [15:0] a, logic [31:0] l, logic [31:0] t);
      int gap;
      if (!steady && $urandom_range(99) < 15) begin
         gap = $urandom_range(1, 6);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start               <= 1'b1;
      req_cmd             <= cmd;
      req_target_address  <= a;
      req_pulse_length_ms <= l;
      req_tick_time_us    <= t;
      do @(posedge clock); while (busy);
      sb.note_word(cmd, a, l, t);
   endtask

   task drain();
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task write_csr(logic [tpst_pkg::CSR_IDX_W-1:0] idx, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_register(idx, data);
   endtask

   task set_config(logic cfr, logic [31:0] period, logic [15:0] unused, logic [15:0] mask,
                   logic [15:0] region, bit spare);
      drain();
      repeat (SLOTS + 6) @(posedge clock);
      write_csr(tpst_pkg::REG_CHECK_FIXED_RATE, {31'd0, cfr});
      write_csr(tpst_pkg::REG_SCAN_PERIOD, period);
      write_csr(tpst_pkg::REG_UNUSED_ADDRESS, {16'd0, unused});
      write_csr(tpst_pkg::REG_REGION_MASK, {16'd0, mask});
      write_csr(tpst_pkg::REG_CONSTANT_REGION, {16'd0, region});
      if (spare)
         for (int i = tpst_pkg::REG_CONSTANT_REGION + 1; i < (1 << tpst_pkg::CSR_IDX_W);
              i++)
            write_csr(i[tpst_pkg::CSR_IDX_W-1:0], $urandom);
      csr_valid <= 1'b0;
   endtask

   task send_random_word();
      logic        cmd;
      logic [15:0] a;
      logic [31:0] l;
      logic [31:0] t;
      logic [31:0] base;
      int r;
      cmd = ($urandom_range(99) < 40) ? tpst_pkg::CMD_TICK : tpst_pkg::CMD_ARM;
      a = 16'($urandom);
      l = $urandom;
      t = $urandom;
      r = $urandom_range(99);
      if (cmd == tpst_pkg::CMD_ARM) begin
         if (r < 70)
            a = addr_pool[$urandom_range(POOL - 1)];
         else if (r < 80)
            a = sb.unused_address;
         else if (r < 88)
            a = (a & ~sb.region_mask) | (sb.constant_region & sb.region_mask);
         r = $urandom_range(99);
         if (r < 10)
            l = '0;
         else if (r < 15)
            l = 32'hFFFF_FFFF - $urandom_range(0, 5);
         else
            l = $urandom_range(1, 12);
      end else if (sb.check_fixed_rate && sb.scan_period != '0) begin
         base = (sb.previous_tick_us != '0) ? sb.previous_tick_us : wall_us;
         t = base + sb.scan_period;
         if (r < 3)
            t = '0;
         else if (r < 15)
            t = t + $urandom_range(1, 500);
         else
            wall_us = t;
      end else begin
         wall_us = wall_us + ((r < 70) ? $urandom_range(200, 3000) : $urandom_range(0, 199));
         t = wall_us;
      end
      send_word(cmd, a, l, t);
   endtask

   initial begin
      for (int i = 0; i < POOL; i++) addr_pool[i] = 16'($urandom_range(0, 16'hEFFF));
      wall_us = 32'd100000;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reuse, wrapped deadline, bounds, full table, field extremes
      send_word(tpst_pkg::CMD_TICK, 16'($urandom), $urandom, 32'd0);
      send_word(tpst_pkg::CMD_ARM, 16'h0000, 32'd0, $urandom);
      send_word(tpst_pkg::CMD_ARM, 16'h0123, 32'd1, $urandom);
      send_word(tpst_pkg::CMD_ARM, 16'hFFFF, 32'd5, $urandom);
      send_word(tpst_pkg::CMD_ARM, 16'hF000, 32'd5, $urandom);
      send_word(tpst_pkg::CMD_ARM, 16'hFABC, 32'd5, $urandom);
      send_word(tpst_pkg::CMD_ARM, 16'hEFFF, 32'hFFFF_FFFF, $urandom);
      send_word(tpst_pkg::CMD_ARM, 16'h0123, 32'd2, $urandom);
      send_word(tpst_pkg::CMD_TICK, 16'($urandom), $urandom, 32'd1500);
      send_word(tpst_pkg::CMD_TICK, 16'($urandom), $urandom, 32'd3000);
      send_word(tpst_pkg::CMD_TICK, 16'($urandom), $urandom, 32'd5000);
      send_word(tpst_pkg::CMD_ARM, 16'h5555, 32'd1, $urandom);
      send_word(tpst_pkg::CMD_ARM, 16'hAAAA, 32'd2, $urandom);
      send_word(tpst_pkg::CMD_ARM, 16'h0F0F, 32'd3, $urandom);
      send_word(tpst_pkg::CMD_ARM, 16'h7FFF, 32'd4, $urandom);
      send_word(tpst_pkg::CMD_ARM, 16'h1111, 32'd5, $urandom);
      send_word(tpst_pkg::CMD_ARM, 16'h2222, 32'd6, $urandom);
      send_word(tpst_pkg::CMD_ARM, 16'h3333, 32'd7, $urandom);
      send_word(tpst_pkg::CMD_ARM, 16'h4444, 32'd1, $urandom);
      send_word(tpst_pkg::CMD_TICK, 16'($urandom), $urandom, 32'h5555_5555);
      send_word(tpst_pkg::CMD_TICK, 16'($urandom), $urandom, 32'hAAAA_AAAA);
      send_word(tpst_pkg::CMD_TICK, 16'($urandom), $urandom, 32'hFFFF_FFFF);

      set_config(1'b1, 32'd1000, 16'h0000, 16'hFFFF, 16'h8000, 1'b1);
      repeat (150) send_random_word();

      set_config(1'b1, 32'hFFFF_FFFF, 16'hFFFF, 16'h0000, 16'h0001, 1'b0);
      repeat (40) send_random_word();

      set_config(1'b0, 32'd0, 16'h1234, tpst_pkg::RST_REGION_MASK,
                 tpst_pkg::RST_CONSTANT_REGION, 1'b0);
      steady = 1'b1;
      repeat (120) send_random_word();
      steady = 1'b0;
      drain();
      repeat (80) send_random_word();

      set_config(1'b1, 32'd0, 16'hFFFF, 16'h0000, 16'h0000, 1'b0);
      repeat (30) send_random_word();

      set_config(1'b0, 32'd2000, 16'hFFFF, 16'hF000, 16'hFFFF, 1'b0);
      repeat (30) send_random_word();

      drain();
      repeat (SLOTS + 10) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("** timed_pulse_slot_table: PASSED **");
      else
         $display("** timed_pulse_slot_table: FAILED **");
      $finish;
   end

endmodule
